// ===== src/mdpvi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpvi_pkg
// Shared constants, types and helpers for the value iteration engine.
// ----------------------------------------------------------------------------
package mdpvi_pkg;

   localparam int NUM_STATES  = 8;
   localparam int NUM_ACTIONS = 4;
   localparam int SW = $clog2(NUM_STATES);
   localparam int AW = $clog2(NUM_ACTIONS);
   localparam int TDEPTH = NUM_STATES * NUM_ACTIONS * NUM_STATES;
   localparam int TW = $clog2(TDEPTH);
   localparam int PW = 17;
   localparam int VW = 32;

   localparam logic [PW-1:0] PROB_ONE = 17'd65536;

   localparam logic [1:0] OP_WR_PROB   = 2'd0;
   localparam logic [1:0] OP_WR_REWARD = 2'd1;
   localparam logic [1:0] OP_RUN       = 2'd2;

   localparam logic [1:0] REG_STATES   = 2'd0;
   localparam logic [1:0] REG_DISCOUNT = 2'd1;
   localparam logic [1:0] REG_EPSILON  = 2'd2;
   localparam logic [1:0] REG_MAXITER  = 2'd3;

   typedef struct packed {
      logic [3:0]  states;
      logic [15:0] discount;
      logic [15:0] epsilon;
      logic [15:0] max_iter;
   } cfg_type;

   // Round-half-up shift right by 16 (arithmetic shift floors, so add half).
   function automatic logic signed [63:0] round16(input logic signed [63:0] x);
      logic signed [63:0] y;
      y = x + 64'sd32768;
      return y >>> 16;
   endfunction

   function automatic logic signed [VW-1:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647)
         return 32'sh7fffffff;
      else if (x < -64'sd2147483648)
         return 32'sh80000000;
      else
         return x[VW-1:0];
   endfunction

endpackage

// ===== src/mdp_value_iteration_top.sv =====
`timescale 1ns / 1ps
// Load words (probability, reward) are accepted one per cycle while the engine is idle.
// A run word clears the values, then each iteration goes through the states in use,
// with the single transition-memory read port feeding one multiply-accumulate. Results
// follow, one state per cycle while the receiver is ready. After reset all 256 entries
// of the transition memory are cleared with no word accepted; rewards and values clear at once.
// ----------------------------------------------------------------------------
// mdp_value_iteration_top
// Value iteration engine: transition table in RAM, rewards and values in registers,
// one shared multiply-accumulate unit.
module mdp_value_iteration_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] op, [4:2] state_index, [6:5] action_index, [9:7] next_state_index,
   // [26:10] probability, [58:27] reward, zero fill to 64
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] state_out, [34:3] state_value, [36:35] best_action,
   // [52:37] iterations_done, [53] converged, zero fill to 56
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SW = mdpvi_pkg::SW;
   localparam int AW = mdpvi_pkg::AW;
   localparam int TW = mdpvi_pkg::TW;
   localparam int PW = mdpvi_pkg::PW;
   localparam int VW = mdpvi_pkg::VW;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_VCLR, ST_ACC, ST_DISC, ST_ROUND, ST_SEL, ST_WRITE,
      ST_NEXT, ST_COPY, ST_EMIT
   } state_type;

   mdpvi_pkg::cfg_type cfg;

   mdpvi_csr u_csr (
      .clock(clock), .reset(reset), .csr_psel(csr_psel), .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .cfg(cfg)
   );
   assign csr_pready = 1'b1;

   // Input field unpacking
   logic [1:0]  in_op;
   logic [SW-1:0] in_s, in_n;
   logic [AW-1:0] in_a;
   logic [PW-1:0] in_p;
   logic [VW-1:0] in_r;
   assign in_op = req_tdata[1:0];
   assign in_s  = req_tdata[4:2];
   assign in_a  = req_tdata[6:5];
   assign in_n  = req_tdata[9:7];
   assign in_p  = req_tdata[26:10];
   assign in_r  = req_tdata[58:27];

   state_type     state_ff;
   logic [TW:0]   clr_ff;
   logic [SW:0]   n_ff;
   logic [15:0]   limit_ff;
   logic [SW-1:0] s_ff, t_ff;
   logic [AW-1:0] a_ff;
   logic [SW:0]   tr_ff;            // issued read count within one sum
   logic [0:0]    pipe_ff;          // valid bit of read pipeline
   logic [SW-1:0] pipe_t_ff;
   logic signed [63:0] acc_ff;
   logic signed [63:0] q_ff;
   logic signed [63:0] best_ff;
   logic [AW-1:0] best_a_ff;
   logic [15:0]   iter_ff;
   logic          conv_ff;
   logic          pend_ff;          // an output word waits
   logic [VW-1:0] reward_ff [mdpvi_pkg::NUM_STATES];
   logic [VW-1:0] cur_ff   [mdpvi_pkg::NUM_STATES];
   logic [VW-1:0] prev_ff  [mdpvi_pkg::NUM_STATES];
   logic [AW-1:0] pol_ff   [mdpvi_pkg::NUM_STATES];
   logic [55:0]   out_ff;
   logic          last_ff;

   // Transition memory
   logic          t_we;
   logic [TW-1:0] t_waddr, t_raddr;
   logic [PW-1:0] t_wdata, t_rdata;

   mdpvi_ram #(.WIDTH(PW), .DEPTH(mdpvi_pkg::TDEPTH)) u_tmem (
      .clock(clock), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
      .raddr(t_raddr), .rdata(t_rdata)
   );

   logic accept;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;

   always_comb begin
      t_we    = 1'b0;
      t_waddr = {in_s, in_a, in_n};
      t_wdata = (in_p > mdpvi_pkg::PROB_ONE) ? mdpvi_pkg::PROB_ONE : in_p;
      if (state_ff == ST_CLEAR) begin
         t_we    = 1'b1;
         t_waddr = clr_ff[TW-1:0];
         t_wdata = '0;
      end else if (accept && in_op == mdpvi_pkg::OP_WR_PROB) begin
         t_we = 1'b1;
      end
   end
   assign t_raddr = {s_ff, a_ff, t_ff};

   // Product of probability and previous value (17 x 32 bits)
   logic signed [63:0] prod;
   logic signed [VW-1:0] pv;
   assign pv   = prev_ff[pipe_t_ff];
   assign prod = 64'(signed'({1'b0, t_rdata})) * 64'(signed'(pv));

   // Discount multiply; the product is rounded in ST_ROUND
   logic signed [63:0] disc_prod;
   assign disc_prod = q_ff * 64'(signed'({1'b0, cfg.discount}));

   logic signed [63:0] newv64;
   logic signed [VW-1:0] newv;
   logic signed [63:0] diff;
   assign newv64 = best_ff + 64'(signed'(reward_ff[s_ff]));
   assign newv   = mdpvi_pkg::sat32(newv64);
   assign diff   = 64'(signed'(newv)) - 64'(signed'(prev_ff[s_ff]));

   logic [SW:0] n_cfg;
   always_comb begin
      if (cfg.states == 4'd0)
         n_cfg = (SW+1)'(1);
      else if (cfg.states > 4'(mdpvi_pkg::NUM_STATES))
         n_cfg = (SW+1)'(mdpvi_pkg::NUM_STATES);
      else
         n_cfg = cfg.states[SW:0];
   end

   logic last_s;
   assign last_s = ({1'b0, s_ff} == n_ff - (SW+1)'(1));

   assign rsp_tvalid = pend_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = last_ff;

   // Sequencer and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
         pipe_ff  <= '0;
         for (int i = 0; i < mdpvi_pkg::NUM_STATES; i++) begin
            reward_ff[i] <= '0;
            cur_ff[i]    <= '0;
            prev_ff[i]   <= '0;
            pol_ff[i]    <= '0;
         end
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (TW+1)'(mdpvi_pkg::TDEPTH - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (accept && in_op == mdpvi_pkg::OP_WR_REWARD) begin
                  reward_ff[in_s] <= in_r;
               end
               if (accept && in_op == mdpvi_pkg::OP_RUN) begin
                  n_ff     <= n_cfg;
                  limit_ff <= (cfg.max_iter == 16'd0) ? 16'd1 : cfg.max_iter;
                  s_ff     <= '0;
                  iter_ff  <= '0;
                  state_ff <= ST_VCLR;
               end
            end
            ST_VCLR: begin
               // Clear values, then start the first sum
               for (int i = 0; i < mdpvi_pkg::NUM_STATES; i++) begin
                  cur_ff[i]  <= '0;
                  prev_ff[i] <= '0;
                  pol_ff[i]  <= '0;
               end
               s_ff <= '0; a_ff <= '0; t_ff <= '0; tr_ff <= '0;
               acc_ff <= '0; pipe_ff <= '0; conv_ff <= 1'b1;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               // Issue reads for t < n, accumulate each product from the registered read data
               pipe_ff[0] <= (tr_ff < n_ff);
               pipe_t_ff  <= t_ff;
               if (tr_ff < n_ff) begin
                  tr_ff <= tr_ff + 1'b1;
                  t_ff  <= t_ff + 1'b1;
               end
               if (pipe_ff[0]) acc_ff <= acc_ff + prod;
               if (!pipe_ff[0] && tr_ff == n_ff) begin
                  q_ff     <= mdpvi_pkg::round16(acc_ff);
                  state_ff <= ST_DISC;
               end
            end
            ST_DISC: begin
               q_ff     <= disc_prod;
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               q_ff     <= mdpvi_pkg::round16(q_ff);
               state_ff <= ST_SEL;
            end
            ST_SEL: begin
               if (a_ff == '0 || q_ff > best_ff) begin
                  best_ff   <= q_ff;
                  best_a_ff <= a_ff;
               end
               t_ff <= '0; tr_ff <= '0; acc_ff <= '0; pipe_ff <= '0;
               if (a_ff == AW'(mdpvi_pkg::NUM_ACTIONS - 1)) begin
                  state_ff <= ST_WRITE;
               end else begin
                  a_ff     <= a_ff + 1'b1;
                  state_ff <= ST_ACC;
               end
            end
            ST_WRITE: begin
               cur_ff[s_ff] <= newv;
               pol_ff[s_ff] <= best_a_ff;
               if ((diff < 0 ? -diff : diff) >= 64'(cfg.epsilon)) conv_ff <= 1'b0;
               a_ff <= '0;
               state_ff <= ST_NEXT;
            end
            ST_NEXT: begin
               if (last_s) begin
                  iter_ff  <= iter_ff + 1'b1;
                  state_ff <= ST_COPY;
               end else begin
                  s_ff     <= s_ff + 1'b1;
                  state_ff <= ST_ACC;
               end
            end
            ST_COPY: begin
               s_ff <= '0;
               if (conv_ff || iter_ff >= limit_ff) begin
                  state_ff <= ST_EMIT;
               end else begin
                  for (int i = 0; i < mdpvi_pkg::NUM_STATES; i++) prev_ff[i] <= cur_ff[i];
                  conv_ff  <= 1'b1;
                  state_ff <= ST_ACC;
               end
            end
            ST_EMIT: begin
               // Load the output register when free, drop it when taken
               if (!pend_ff || rsp_tready) begin
                  pend_ff <= 1'b1;
                  out_ff  <= {2'b00, conv_ff, iter_ff, pol_ff[s_ff], cur_ff[s_ff], s_ff};
                  last_ff <= last_s;
                  s_ff    <= s_ff + 1'b1;
                  if (last_s) state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (pend_ff && rsp_tready && state_ff != ST_EMIT) pend_ff <= 1'b0;
      end
   end

endmodule

// ===== src/mdpvi_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpvi_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mdpvi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== src/mdpvi_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpvi_csr
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module mdpvi_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output mdpvi_pkg::cfg_type   cfg
);

   mdpvi_pkg::cfg_type cfg_ff;
   logic [1:0]         idx;

   assign idx = csr_paddr[3:2];
   assign cfg = cfg_ff;

   // Write on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.states   <= 4'd5;
         cfg_ff.discount <= 16'd58982;
         cfg_ff.epsilon  <= 16'd7;
         cfg_ff.max_iter <= 16'd1000;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'd0) begin
         case (idx)
            mdpvi_pkg::REG_STATES:   cfg_ff.states   <= csr_pwdata[3:0];
            mdpvi_pkg::REG_DISCOUNT: cfg_ff.discount <= csr_pwdata[15:0];
            mdpvi_pkg::REG_EPSILON:  cfg_ff.epsilon  <= csr_pwdata[15:0];
            mdpvi_pkg::REG_MAXITER:  cfg_ff.max_iter <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (idx)
         mdpvi_pkg::REG_STATES:   csr_prdata = {28'd0, cfg_ff.states};
         mdpvi_pkg::REG_DISCOUNT: csr_prdata = {16'd0, cfg_ff.discount};
         mdpvi_pkg::REG_EPSILON:  csr_prdata = {16'd0, cfg_ff.epsilon};
         mdpvi_pkg::REG_MAXITER:  csr_prdata = {16'd0, cfg_ff.max_iter};
         default:                 csr_prdata = 32'd0;
      endcase
   end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the value iteration engine. Load words fill the
// transition and reward tables, run words start value iteration; a local
// fixed-point model of the engine predicts every result word, and a checker
// compares each word from the result stream against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int SETTLE      = 40;

   typedef struct {
      logic [2:0]  state_id;
      logic [31:0] value;
      logic [1:0]  action;
      logic [15:0] iters;
      logic        conv;
      logic        last;
   } state_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // shadow of the engine tables and registers
   logic [16:0]        prob_tab [mdpvi_pkg::NUM_STATES][mdpvi_pkg::NUM_ACTIONS]
                                [mdpvi_pkg::NUM_STATES];
   logic signed [31:0] reward_tab [mdpvi_pkg::NUM_STATES];
   logic [3:0]  cfg_states = 4'd5;
   logic [15:0] cfg_discount = 16'd58982;
   logic [15:0] cfg_epsilon = 16'd7;
   logic [15:0] cfg_max_iter = 16'd1000;

   state_result_type pending_results[$];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int error_count = 0;
   int cycle_count = 0;
   int runs_sent = 0;
   int words_sent = 0;
   int results_seen = 0;

   always #10 clock = ~clock;

   mdp_value_iteration_top dut (.*);

   // timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // randomly stall the result stream
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want,
               cycle_count);
      error_count++;
   endtask

   function automatic logic signed [31:0] clamp_q16(longint x);
      if (x > 64'sd2147483647) return 32'sh7fffffff;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

   // run value iteration on the shadow tables and queue one result per state
   function automatic void predict_values();
      int n, lim, iters;
      bit conv;
      longint vcur[mdpvi_pkg::NUM_STATES], vprev[mdpvi_pkg::NUM_STATES];
      logic [1:0] policy[mdpvi_pkg::NUM_STATES];
      longint acc, q, best, d;
      int best_a;
      state_result_type r;
      n = cfg_states;
      if (n < 1) n = 1;
      if (n > mdpvi_pkg::NUM_STATES) n = mdpvi_pkg::NUM_STATES;
      lim = (cfg_max_iter == 0) ? 1 : cfg_max_iter;
      foreach (vcur[i]) vcur[i] = 0;
      iters = 0;
      forever begin
         vprev = vcur;
         conv = 1'b1;
         for (int s = 0; s < n; s++) begin
            best = 0;
            best_a = 0;
            for (int a = 0; a < mdpvi_pkg::NUM_ACTIONS; a++) begin
               acc = 0;
               for (int t = 0; t < n; t++)
                  acc += longint'(prob_tab[s][a][t]) * vprev[t];
               q = (acc + 32768) >>> 16;
               q = (q * longint'(cfg_discount) + 32768) >>> 16;
               if (a == 0 || q > best) begin
                  best = q;
                  best_a = a;
               end
            end
            vcur[s] = clamp_q16(best + longint'(reward_tab[s]));
            policy[s] = best_a[1:0];
            d = vcur[s] - vprev[s];
            if (d < 0) d = -d;
            if (d >= longint'(cfg_epsilon)) conv = 1'b0;
         end
         iters++;
         if (conv || iters >= lim) break;
      end
      for (int s = 0; s < n; s++) begin
         r.state_id = s[2:0];
         r.value = vcur[s][31:0];
         r.action = policy[s];
         r.iters = iters[15:0];
         r.conv = conv;
         r.last = (s + 1 == n);
         pending_results = {pending_results, r};
      end
   endfunction

   // apply an accepted word to the shadow state
   function automatic void absorb_word(logic [63:0] w);
      logic [16:0] p;
      case (w[1:0])
         mdpvi_pkg::OP_WR_PROB: begin
            p = w[26:10];
            if (p > mdpvi_pkg::PROB_ONE) p = mdpvi_pkg::PROB_ONE;
            prob_tab[w[4:2]][w[6:5]][w[9:7]] = p;
         end
         mdpvi_pkg::OP_WR_REWARD: reward_tab[w[4:2]] = w[58:27];
         mdpvi_pkg::OP_RUN: begin
            runs_sent++;
            predict_values();
         end
         default: ;
      endcase
   endfunction

   // check each result word against the oldest prediction
   always @(posedge clock) begin
      state_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result word, state", rsp_tdata[2:0], -1);
         end else begin
            e = pending_results.pop_front();
            if (rsp_tdata[2:0] !== e.state_id)
               report_mismatch("state_out", rsp_tdata[2:0], e.state_id);
            if (rsp_tdata[34:3] !== e.value)
               report_mismatch("state_value", $signed(rsp_tdata[34:3]), $signed(e.value));
            if (rsp_tdata[36:35] !== e.action)
               report_mismatch("best_action", rsp_tdata[36:35], e.action);
            if (rsp_tdata[52:37] !== e.iters)
               report_mismatch("iterations_done", rsp_tdata[52:37], e.iters);
            if (rsp_tdata[53] !== e.conv)
               report_mismatch("converged", rsp_tdata[53], e.conv);
            if (rsp_tlast !== e.last)
               report_mismatch("last", rsp_tlast, e.last);
         end
      end
   end

   // send one word; valid stays high after acceptance unless the next send idles
   task automatic send_word(logic [63:0] w);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= w;
      do @(posedge clock); while (!req_tready);
      absorb_word(w);
      words_sent++;
      @(negedge clock);
   endtask

   function automatic logic [63:0] pack_word(logic [1:0] op, logic [2:0] si,
                                             logic [1:0] ai, logic [2:0] ni,
                                             logic [16:0] p, logic [31:0] rw);
      return {5'd0, rw, p, ni, ai, si, op};
   endfunction

   task automatic send_prob(int s, int a, int t, logic [16:0] p);
      send_word(pack_word(mdpvi_pkg::OP_WR_PROB, s[2:0], a[1:0], t[2:0], p,
                          $urandom()));
   endtask

   task automatic send_reward(int s, logic [31:0] rw);
      send_word(pack_word(mdpvi_pkg::OP_WR_REWARD, s[2:0], 2'($urandom()),
                          3'($urandom()), 17'($urandom()), rw));
   endtask

   task automatic send_run();
      send_word(pack_word(mdpvi_pkg::OP_RUN, 3'($urandom()), 2'($urandom()),
                          3'($urandom()), 17'($urandom()), $urandom()));
   endtask

   // wait until every prediction has been consumed, then let loads finish
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // two-phase register write; call only while idle
   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         mdpvi_pkg::REG_STATES:   cfg_states = val[3:0];
         mdpvi_pkg::REG_DISCOUNT: cfg_discount = val[15:0];
         mdpvi_pkg::REG_EPSILON:  cfg_epsilon = val[15:0];
         default:                 cfg_max_iter = val[15:0];
      endcase
   endtask

   task automatic write_config(int st, int disc, int eps, int mi);
      drain();
      write_reg(mdpvi_pkg::REG_STATES, st);
      write_reg(mdpvi_pkg::REG_DISCOUNT, disc);
      write_reg(mdpvi_pkg::REG_EPSILON, eps);
      write_reg(mdpvi_pkg::REG_MAXITER, mi);
   endtask

   // keep iteration counts low so runs stay short
   task automatic random_config();
      int st, eps;
      st = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8);
      eps = ($urandom_range(7) == 0) ? 0 : $urandom_range(65535);
      write_config(st, $urandom_range(65535), eps, $urandom_range(1, 24));
   endtask

   // defaults on empty tables: zero values, action 0 everywhere
   task automatic test_reset_defaults();
      send_run();
   endtask

   // field extremes, saturation, clamped probability, unused op, state counts
   task automatic test_directed_loads();
      send_reward(0, 32'h7fffffff);
      send_reward(7, 32'h80000000);
      send_reward(3, 32'hfffe0000);
      send_prob(0, 0, 0, 17'h1ffff);
      send_prob(7, 3, 7, mdpvi_pkg::PROB_ONE);
      send_prob(1, 2, 3, 17'd0);
      send_prob(1, 1, 0, 17'd32768);
      send_prob(2, 3, 1, 17'd65535);
      send_prob(3, 2, 2, 17'd40000);
      send_word(pack_word(2'd3, 3'd5, 2'd1, 3'd2, 17'h1ffff, 32'hffffffff));
      send_run();
      write_config(8, 58982, 7, 1000);
      send_run();
      write_config(0, 58982, 7, 1000);
      send_run();
      write_config(15, 58982, 7, 1000);
      send_run();
   endtask

   // register extremes: zero threshold, minimum and maximum limits and discounts
   task automatic test_register_extremes();
      write_config(8, 58982, 0, 3);
      send_run();
      write_config(4, 65535, 65535, 0);
      send_run();
      write_config(8, 0, 65535, 65535);
      send_run();
      write_config(1, 65535, 0, 1);
      send_run();
      write_config(8, 65535, 65535, 65535);
      send_run();
   endtask

   // random loads and runs, occasionally reconfigured, under one idle mix
   task automatic test_random_traffic(int n_items, int idle_pct, int stall_pct);
      int r;
      logic [16:0] p;
      drain();
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      random_config();
      for (int i = 0; i < n_items; i++) begin
         r = $urandom_range(99);
         if (r < 8) begin
            if ($urandom_range(2) == 0) random_config();
            send_run();
         end else if (r < 12) begin
            send_word(pack_word(2'd3, 3'($urandom()), 2'($urandom()), 3'($urandom()),
                                17'($urandom()), $urandom()));
         end else if (r < 75) begin
            r = $urandom_range(99);
            if (r < 60) p = 17'($urandom_range(16384));
            else if (r < 85) p = 17'($urandom());
            else p = mdpvi_pkg::PROB_ONE;
            send_prob($urandom_range(7), $urandom_range(3), $urandom_range(7), p);
         end else begin
            send_reward($urandom_range(7), ($urandom_range(3) == 0) ? $urandom() :
                        $urandom_range(0, 32'h000fffff) - 32'h00080000);
         end
      end
      send_run();
   endtask

   initial begin
      foreach (prob_tab[s, a, t]) prob_tab[s][a][t] = '0;
      foreach (reward_tab[s]) reward_tab[s] = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_loads();
      test_register_extremes();
      test_random_traffic(90, 0, 0);
      test_random_traffic(90, 79, 0);
      test_random_traffic(90, 0, 79);
      test_random_traffic(90, 21, 21);
      drain();
      repeat (SETTLE) @(negedge clock);
      $display("covered %0d words in, %0d runs, %0d result words checked",
               words_sent, runs_sent, results_seen);
      $display("idle mixes: none, sender gaps, receiver stalls, both; %0d cycles",
               cycle_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d results outstanding", error_count,
                  pending_results.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
